// ----- hdl/md5_pkg.sv -----
// Package with the constants, round tables and helper functions of the MD5 engine.
`timescale 1ns / 1ps

package md5_pkg;

  localparam logic [31:0] InitA = 32'h67452301;
  localparam logic [31:0] InitB = 32'hefcdab89;
  localparam logic [31:0] InitC = 32'h98badcfe;
  localparam logic [31:0] InitD = 32'h10325476;

  localparam logic [7:0] PadByte     = 8'h80;
  localparam int unsigned BlockBytes = 64;
  localparam int unsigned LenBytePos = 56;
  localparam int unsigned NumWords   = 16;
  localparam int unsigned NumRounds  = 64;

  typedef logic [5:0] round_idx_t;

  function automatic logic [31:0] md5_sine(input round_idx_t idx);
    logic [31:0] k;
    case (idx)
      6'd0:  k = 32'hd76aa478;
      6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;
      6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;
      6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;
      6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;
      6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;
      6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;
      6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;
      6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;
      6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;
      6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;
      6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;
      6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;
      6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;
      6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;
      6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;
      6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;
      6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;
      6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;
      6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;
      6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;
      6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;
      6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;
      6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;
      6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;
      6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;
      6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;
      6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;
      6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;
      6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;
      6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;
      6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;
      6'd63: k = 32'heb86d391;
      default: k = '0;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] md5_shift(input round_idx_t idx);
    logic [4:0] s;
    case ({idx[5:4], idx[1:0]})
      4'd0:  s = 5'd7;
      4'd1:  s = 5'd12;
      4'd2:  s = 5'd17;
      4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;
      4'd5:  s = 5'd9;
      4'd6:  s = 5'd14;
      4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;
      4'd9:  s = 5'd11;
      4'd10: s = 5'd16;
      4'd11: s = 5'd23;
      4'd12: s = 5'd6;
      4'd13: s = 5'd10;
      4'd14: s = 5'd15;
      4'd15: s = 5'd21;
      default: s = 5'd0;
    endcase
    return s;
  endfunction

  // Message word selected by each round group.
  function automatic logic [3:0] md5_word_sel(input round_idx_t idx);
    logic [3:0] i;
    logic [3:0] g;
    i = idx[3:0];
    case (idx[5:4])
      2'd0:    g = i;
      2'd1:    g = 4'((i << 2) + i + 4'd1);
      2'd2:    g = 4'((i << 1) + i + 4'd5);
      2'd3:    g = 4'((i << 3) - i);
      default: g = i;
    endcase
    return g;
  endfunction

  function automatic logic [31:0] md5_func(input logic [1:0] grp, input logic [31:0] b,
                                           input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    case (grp)
      2'd0:    f = (b & c) | (~b & d);
      2'd1:    f = (b & d) | (c & ~d);
      2'd2:    f = b ^ c ^ d;
      2'd3:    f = c ^ (b | ~d);
      default: f = '0;
    endcase
    return f;
  endfunction

endpackage

// ----- hdl/md5_in_if.sv -----
// Request channel carrying message bytes and the end marker into the MD5 engine.
`timescale 1ns / 1ps

interface md5_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       message_end;

  modport source (output valid, output data_byte, output byte_present, output message_end,
                  input ready);
  modport sink (input valid, input data_byte, input byte_present, input message_end,
                output ready);
endinterface

// ----- hdl/md5_out_if.sv -----
// Request channel carrying the four digest words out of the MD5 engine.
`timescale 1ns / 1ps

interface md5_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word_a;
  logic [31:0] digest_word_b;
  logic [31:0] digest_word_c;
  logic [31:0] digest_word_d;

  modport source (output valid, output digest_word_a, output digest_word_b,
                  output digest_word_c, output digest_word_d, input ready);
  modport sink (input valid, input digest_word_a, input digest_word_b,
                input digest_word_c, input digest_word_d, output ready);
endinterface

// ----- hdl/md5_hash_engine_unit.sv -----
// MD5 digest engine: byte intake, block buffer, iterative round unit and digest output.
//
// Each request carries at most one message byte and may mark the end of the message. A byte
// that does not complete a 64-byte block is taken without stalling intake, unless it also ends
// the message. The request holding the last byte of a block stalls intake while one shared
// round unit runs the 64 MD5 steps at one step per cycle and the add state then adds the result
// into the chaining words. An end request costs a padding step and one compression, or a
// padding step, a length step and two compressions when fewer than nine bytes remain in the
// block. The digest sits in an output register; new bytes are taken while it waits, and a
// later digest waits only for it to go.
`timescale 1ns / 1ps

module md5_hash_engine_unit
  import md5_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  md5_in_if.sink    data_in_i,
  md5_out_if.source digest_o
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StPad   = 3'd1;
  localparam logic [2:0] StLen   = 3'd2;
  localparam logic [2:0] StRound = 3'd3;
  localparam logic [2:0] StAdd   = 3'd4;

  localparam logic [1:0] PhData  = 2'd0;
  localparam logic [1:0] PhExtra = 2'd1;
  localparam logic [1:0] PhFinal = 2'd2;

  logic [2:0]  state_q, state_d;
  logic [1:0]  phase_q, phase_d;
  logic        fin_q, fin_d;
  logic [63:0] count_q, count_d;
  round_idx_t  round_q, round_d;
  logic [31:0] chain_q [4];
  logic [31:0] work_q [4];
  logic [31:0] buf_q [NumWords];
  logic [31:0] dig_q [4];
  logic        out_valid_q, out_valid_d;

  logic        accept;
  logic [5:0]  pos;
  logic        start_round;
  logic        load_out;
  logic [63:0] bit_len;
  logic [31:0] step_sum;
  logic [63:0] rot_wide;
  logic [31:0] new_b;

  assign accept  = data_in_i.valid && data_in_i.ready;
  assign pos     = count_q[5:0];
  assign bit_len = {count_q[60:0], 3'b000};
  assign data_in_i.ready = (state_q == StIdle);

  assign step_sum = work_q[0] + md5_func(round_q[5:4], work_q[1], work_q[2], work_q[3])
                    + md5_sine(round_q) + buf_q[md5_word_sel(round_q)];
  assign rot_wide = {step_sum, step_sum} << md5_shift(round_q);
  assign new_b    = work_q[1] + rot_wide[63:32];

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    fin_d       = fin_q;
    count_d     = count_q;
    round_d     = round_q;
    out_valid_d = out_valid_q;
    start_round = 1'b0;
    load_out    = 1'b0;
    if (out_valid_q && digest_o.ready) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      StIdle: begin
        if (accept) begin
          fin_d   = data_in_i.message_end;
          phase_d = PhData;
          if (data_in_i.byte_present) begin
            count_d = count_q + 64'd1;
          end
          if (data_in_i.byte_present && (pos == 6'(BlockBytes - 1))) begin
            state_d     = StRound;
            start_round = 1'b1;
          end else if (data_in_i.message_end) begin
            state_d = StPad;
          end
        end
      end
      StPad: begin
        phase_d     = (pos >= 6'(LenBytePos)) ? PhExtra : PhFinal;
        state_d     = StRound;
        start_round = 1'b1;
      end
      StLen: begin
        phase_d     = PhFinal;
        state_d     = StRound;
        start_round = 1'b1;
      end
      StRound: begin
        round_d = round_q + 6'd1;
        if (round_q == 6'(NumRounds - 1)) begin
          state_d = StAdd;
        end
      end
      StAdd: begin
        case (phase_q)
          PhData:  state_d = fin_q ? StPad : StIdle;
          PhExtra: state_d = StLen;
          PhFinal: begin
            if (!out_valid_q || digest_o.ready) begin
              load_out    = 1'b1;
              out_valid_d = 1'b1;
              count_d     = '0;
              fin_d       = 1'b0;
              state_d     = StIdle;
            end
          end
          default: state_d = StIdle;
        endcase
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      phase_q     <= PhData;
      fin_q       <= 1'b0;
      count_q     <= '0;
      round_q     <= '0;
      out_valid_q <= 1'b0;
      chain_q[0]  <= InitA;
      chain_q[1]  <= InitB;
      chain_q[2]  <= InitC;
      chain_q[3]  <= InitD;
      for (int i = 0; i < 4; i++) begin
        work_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      fin_q       <= fin_d;
      count_q     <= count_d;
      round_q     <= round_d;
      out_valid_q <= out_valid_d;
      if (start_round) begin
        for (int i = 0; i < 4; i++) begin
          work_q[i] <= chain_q[i];
        end
      end else if (state_q == StRound) begin
        work_q[0] <= work_q[3];
        work_q[1] <= new_b;
        work_q[2] <= work_q[1];
        work_q[3] <= work_q[2];
      end
      if (load_out) begin
        chain_q[0] <= InitA;
        chain_q[1] <= InitB;
        chain_q[2] <= InitC;
        chain_q[3] <= InitD;
      end else if ((state_q == StAdd) && (phase_q != PhFinal)) begin
        for (int i = 0; i < 4; i++) begin
          chain_q[i] <= chain_q[i] + work_q[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      for (int i = 0; i < 4; i++) begin
        dig_q[i] <= chain_q[i] + work_q[i];
      end
    end
  end

  // Block buffer: byte lanes on intake, padding with zero fill, and length fill.
  always_ff @(posedge clk_i) begin
    if (accept && data_in_i.byte_present) begin
      buf_q[pos[5:2]][pos[1:0]*8 +: 8] <= data_in_i.data_byte;
    end else if (state_q == StPad) begin
      for (int w = 0; w < NumWords; w++) begin
        if (4'(w) > pos[5:2]) begin
          buf_q[w] <= '0;
        end else if (4'(w) == pos[5:2]) begin
          for (int l = 0; l < 4; l++) begin
            if (2'(l) == pos[1:0]) begin
              buf_q[w][l*8 +: 8] <= PadByte;
            end else if (2'(l) > pos[1:0]) begin
              buf_q[w][l*8 +: 8] <= '0;
            end
          end
        end
      end
      if (pos < 6'(LenBytePos)) begin
        buf_q[NumWords-2] <= bit_len[31:0];
        buf_q[NumWords-1] <= bit_len[63:32];
      end
    end else if (state_q == StLen) begin
      for (int w = 0; w < NumWords - 2; w++) begin
        buf_q[w] <= '0;
      end
      buf_q[NumWords-2] <= bit_len[31:0];
      buf_q[NumWords-1] <= bit_len[63:32];
    end
  end

  assign digest_o.valid         = out_valid_q;
  assign digest_o.digest_word_a = dig_q[0];
  assign digest_o.digest_word_b = dig_q[1];
  assign digest_o.digest_word_c = dig_q[2];
  assign digest_o.digest_word_d = dig_q[3];

endmodule

// ----- dv/md5_hash_engine_unit_tb.sv -----
// Testbench that streams random byte messages into the MD5 engine and checks every digest.
`timescale 1ns / 1ps

module md5_hash_engine_unit_tb;
  import md5_pkg::*;

  localparam logic [31:0] StepConst [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam int unsigned StepRot [16] = '{
    7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
  };

  localparam int unsigned EdgeLengths [8] = '{55, 56, 57, 63, 64, 65, 119, 120};

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } digest_t;

  class digest_tracker;
    logic [31:0] chain [4];
    logic [31:0] words [16];
    logic [63:0] byte_total;
    digest_t     digests_due [$];
    int unsigned errors;

    function new();
      errors = 0;
      restart();
    endfunction

    function void restart();
      chain[0]   = InitA;
      chain[1]   = InitB;
      chain[2]   = InitC;
      chain[3]   = InitD;
      byte_total = '0;
      foreach (words[i]) words[i] = '0;
    endfunction

    function void put_byte(int unsigned pos, logic [7:0] value);
      words[pos / 4][8 * (pos % 4) +: 8] = value;
    endfunction

    function void compress();
      logic [31:0] a, b, c, d, f, t;
      int unsigned g, s;
      a = chain[0];
      b = chain[1];
      c = chain[2];
      d = chain[3];
      for (int i = 0; i < 64; i++) begin
        case (i / 16)
          0: begin
            f = (b & c) | (~b & d);
            g = i;
          end
          1: begin
            f = (b & d) | (c & ~d);
            g = 5 * i + 1;
          end
          2: begin
            f = b ^ c ^ d;
            g = 3 * i + 5;
          end
          default: begin
            f = c ^ (b | ~d);
            g = 7 * i;
          end
        endcase
        t = a + f + StepConst[i] + words[g % 16];
        s = StepRot[4 * (i / 16) + i % 4];
        a = d;
        d = c;
        c = b;
        b = b + ((t << s) | (t >> (32 - s)));
      end
      chain[0] += a;
      chain[1] += b;
      chain[2] += c;
      chain[3] += d;
    endfunction

    function void take_request(logic [7:0] data_byte, logic byte_present, logic message_end);
      int unsigned pos;
      logic [63:0] len_bits;
      if (byte_present) begin
        pos = 32'(byte_total[5:0]);
        put_byte(pos, data_byte);
        byte_total++;
        if (pos == BlockBytes - 1) compress();
      end
      if (!message_end) return;
      len_bits = byte_total << 3;
      pos = 32'(byte_total[5:0]);
      put_byte(pos, PadByte);
      pos++;
      if (pos > LenBytePos) begin
        while (pos < BlockBytes) begin
          put_byte(pos, 8'h00);
          pos++;
        end
        compress();
        pos = 0;
      end
      while (pos < LenBytePos) begin
        put_byte(pos, 8'h00);
        pos++;
      end
      words[14] = len_bits[31:0];
      words[15] = len_bits[63:32];
      compress();
      digests_due.push_back('{chain[0], chain[1], chain[2], chain[3]});
      restart();
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch at %0t: %s got %08h want %08h", $time, what, got, want);
      errors++;
    endtask

    task check_digest(digest_t got);
      digest_t want;
      if (digests_due.size() == 0) begin
        report_mismatch("digest with none outstanding, word a", got.a, 32'h0);
        return;
      end
      want = digests_due.pop_front();
      if (got.a !== want.a) report_mismatch("digest word a", got.a, want.a);
      if (got.b !== want.b) report_mismatch("digest word b", got.b, want.b);
      if (got.c !== want.c) report_mismatch("digest word c", got.c, want.c);
      if (got.d !== want.d) report_mismatch("digest word d", got.d, want.d);
    endtask

    function int unsigned outstanding();
      return digests_due.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  md5_in_if  in_ch ();
  md5_out_if out_ch ();

  md5_hash_engine_unit u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .data_in_i (in_ch),
    .digest_o  (out_ch)
  );

  digest_tracker tracker;
  int unsigned   send_idle_pct;
  int unsigned   stall_pct;
  int unsigned   requests_sent;
  int unsigned   messages_sent;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_ch.valid && out_ch.ready) begin
        tracker.check_digest('{out_ch.digest_word_a, out_ch.digest_word_b,
                               out_ch.digest_word_c, out_ch.digest_word_d});
      end
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_request(logic [7:0] data_byte, logic byte_present, logic message_end);
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_ch.valid        <= 1'b1;
    in_ch.data_byte    <= data_byte;
    in_ch.byte_present <= byte_present;
    in_ch.message_end  <= message_end;
    do @(posedge clk_i); while (!in_ch.ready);
    tracker.take_request(data_byte, byte_present, message_end);
    if (byte_present || message_end) requests_sent++;
  endtask

  task automatic send_message(int unsigned len, bit merge_end);
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(99) < 4) send_request(8'($urandom_range(255)), 1'b0, 1'b0);
      send_request(8'($urandom_range(255)), 1'b1, (merge_end && i == len - 1));
    end
    if (!merge_end || len == 0) send_request(8'($urandom_range(255)), 1'b0, 1'b1);
    messages_sent++;
  endtask

  task automatic wait_for_digests();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (tracker.outstanding() != 0);
  endtask

  initial begin
    int unsigned pick;
    int unsigned len;
    in_ch.valid        = 1'b0;
    in_ch.data_byte    = 8'h00;
    in_ch.byte_present = 1'b0;
    in_ch.message_end  = 1'b0;
    rst_ni             = 1'b0;
    send_idle_pct      = 0;
    stall_pct          = 0;
    requests_sent      = 0;
    messages_sent      = 0;
    tracker            = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The empty message, an ignored request and short messages with the end on or after a byte.
    send_request(8'hff, 1'b0, 1'b1);
    send_request(8'ha5, 1'b0, 1'b0);
    send_request(8'h00, 1'b1, 1'b1);
    send_request(8'h61, 1'b1, 1'b0);
    send_request(8'h62, 1'b1, 1'b0);
    send_request(8'h63, 1'b1, 1'b1);
    send_request(8'hff, 1'b1, 1'b0);
    send_request(8'h80, 1'b1, 1'b0);
    send_request(8'h5a, 1'b0, 1'b1);
    send_request(8'hff, 1'b1, 1'b1);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          send_idle_pct = 81;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 81;
        end
        default: begin
          send_idle_pct = 28;
          stall_pct     = 28;
        end
      endcase
      wait_for_digests();
      while (requests_sent < (ph + 1) * 275 || messages_sent < (ph + 1) * 8 + 5) begin
        pick = $urandom_range(99);
        if (pick < 35) len = $urandom_range(8);
        else if (pick < 55) len = EdgeLengths[$urandom_range(7)];
        else if (pick < 90) len = $urandom_range(60, 9);
        else len = $urandom_range(140, 61);
        send_message(len, 1'($urandom_range(1)));
      end
    end

    wait_for_digests();
    repeat (150) @(posedge clk_i);
    if (tracker.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
